[design/s3a_pkg.sv]
// Shared constants, types and codes for the seven-point stencil block.
package s3a_pkg;
	localparam int DATA_W      = 16;
	localparam int SUM_W       = DATA_W + 3;
	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLS    = 64;
	localparam int SIZE_X_W    = 16;
	localparam int SIZE_YZ_W   = 7;
	localparam int ROW_W       = 6;
	localparam int PLANE_W     = 13;
	localparam int LONG_DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int LONG_AW     = $clog2(LONG_DEPTH);
	localparam int SHORT_DEPTH = MAX_COLS;
	localparam int SHORT_AW    = $clog2(SHORT_DEPTH);
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = QPTR_W + 1;
	localparam int N_W         = SUM_W + 1;
	localparam int RECIP_SHIFT = 23;
	localparam int RECIP_W     = 21;
	localparam int PROD_W      = N_W + RECIP_W;
	// ceil(2^23 / 7); exact quotient for any dividend below 2^20
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(1198373);
	// 3 for round to nearest, 7 * 2^16 keeps the dividend positive
	localparam logic [N_W-1:0] BIAS = N_W'(458755);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

	typedef struct packed {
		logic signed [SUM_W-1:0]  sum;
		logic signed [DATA_W-1:0] center;
		logic                     boundary;
		logic                     last;
	} entry_t;
endpackage

[design/s3a_if.sv]
// Stream channel interfaces for voxels in and results out.
interface s3a_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [s3a_pkg::DATA_W-1:0] voxel_in;
	logic                              is_padding;
	modport source (output valid, voxel_in, is_padding, input ready);
	modport sink (input valid, voxel_in, is_padding, output ready);
endinterface

interface s3a_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [s3a_pkg::DATA_W-1:0] voxel_out;
	logic                              last_of_volume;
	modport source (output valid, voxel_out, last_of_volume, input ready);
	modport sink (input valid, voxel_out, last_of_volume, output ready);
endinterface

[design/s3a_ram.sv]
// Single-port RAM with read-before-write and registered read data.
module s3a_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			rdata     <= mem[addr];
			mem[addr] <= wdata;
		end
	end
endmodule

[design/s3a_front.sv]
// Front end: accepts voxels, runs the delay lines and position counters, sums taps.
module s3a_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [s3a_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [s3a_pkg::CFG_DATA_W-1:0]   cfg_data,
	s3a_in_if.sink                           in_ch,
	input  logic [s3a_pkg::QCNT_W-1:0]       q_count,
	output logic                             enq_valid,
	output s3a_pkg::entry_t                  enq_data
);
	import s3a_pkg::*;

	logic [SIZE_X_W-1:0]  size_x_q;
	logic [SIZE_YZ_W-1:0] size_y_q, size_z_q;
	logic [SIZE_X_W-1:0]  ex;
	logic [SIZE_YZ_W-1:0] ey, ez;
	logic [PLANE_W-1:0]   plane, len_a, len_d;
	logic [SHORT_AW-1:0]  len_bc;
	logic [LONG_AW-1:0]   pa_q, pd_q;
	logic [SHORT_AW-1:0]  pb_q, pc_q;
	logic [PLANE_W-1:0]   fill_q;
	logic [SIZE_X_W-1:0]  oplane_q;
	logic [ROW_W-1:0]     orow_q, ocol_q;
	logic                 valid_s1_q, boundary_s1_q, last_s1_q;
	logic                 push, emit, cfg_hit, restart, is_last, is_bnd;
	logic                 col_end, row_end;
	logic signed [DATA_W-1:0] v, r0_q, r1_q, r2_q;
	logic signed [DATA_W-1:0] a_rd, b_rd, c_rd, d_rd;

	always_comb begin
		ex = (size_x_q < SIZE_X_W'(3)) ? SIZE_X_W'(3) : size_x_q;
		if (size_y_q < SIZE_YZ_W'(3))             ey = SIZE_YZ_W'(3);
		else if (size_y_q > SIZE_YZ_W'(MAX_ROWS)) ey = SIZE_YZ_W'(MAX_ROWS);
		else                                      ey = size_y_q;
		if (size_z_q < SIZE_YZ_W'(3))             ez = SIZE_YZ_W'(3);
		else if (size_z_q > SIZE_YZ_W'(MAX_COLS)) ez = SIZE_YZ_W'(MAX_COLS);
		else                                      ez = size_z_q;
		plane  = PLANE_W'(ey) * PLANE_W'(ez);
		// tap offsets: P-Z, P-1, P, P+1, P+Z and 2P behind the newest voxel
		len_a  = plane - PLANE_W'(ez);
		len_d  = len_a - PLANE_W'(1);
		len_bc = SHORT_AW'(ez - SIZE_YZ_W'(2));
	end

	assign push    = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (q_count + QCNT_W'(valid_s1_q)) < QCNT_W'(QDEPTH);
	assign v       = in_ch.is_padding ? '0 : in_ch.voxel_in;
	assign emit    = fill_q >= plane;
	assign cfg_hit = cfg_we && (cfg_index == CFG_SIZE_X || cfg_index == CFG_SIZE_Y ||
		cfg_index == CFG_SIZE_Z);
	assign col_end = {1'b0, ocol_q} == ez - SIZE_YZ_W'(1);
	assign row_end = {1'b0, orow_q} == ey - SIZE_YZ_W'(1);
	assign is_last = (oplane_q == ex - SIZE_X_W'(1)) && row_end && col_end;
	assign is_bnd  = (oplane_q == '0) || (oplane_q == ex - SIZE_X_W'(1)) ||
		(orow_q == '0) || row_end || (ocol_q == '0) || col_end;
	assign restart = cfg_hit || (push && emit && is_last);

	s3a_ram #(.DEPTH(LONG_DEPTH), .WIDTH(DATA_W)) u_ram_a (
		.clk(clk), .en(push), .addr(pa_q), .wdata(v), .rdata(a_rd));
	s3a_ram #(.DEPTH(SHORT_DEPTH), .WIDTH(DATA_W)) u_ram_b (
		.clk(clk), .en(push), .addr(pb_q), .wdata(a_rd), .rdata(b_rd));
	s3a_ram #(.DEPTH(SHORT_DEPTH), .WIDTH(DATA_W)) u_ram_c (
		.clk(clk), .en(push), .addr(pc_q), .wdata(r2_q), .rdata(c_rd));
	s3a_ram #(.DEPTH(LONG_DEPTH), .WIDTH(DATA_W)) u_ram_d (
		.clk(clk), .en(push), .addr(pd_q), .wdata(c_rd), .rdata(d_rd));

	always_ff @(posedge clk) begin
		if (push) begin
			r0_q <= v;
			r1_q <= b_rd;
			r2_q <= r1_q;
			boundary_s1_q <= is_bnd;
			last_s1_q     <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q   <= SIZE_X_W'(64);
			size_y_q   <= SIZE_YZ_W'(64);
			size_z_q   <= SIZE_YZ_W'(64);
			pa_q       <= '0;
			pb_q       <= '0;
			pc_q       <= '0;
			pd_q       <= '0;
			fill_q     <= '0;
			oplane_q   <= '0;
			orow_q     <= '0;
			ocol_q     <= '0;
			valid_s1_q <= 1'b0;
		end else begin
			valid_s1_q <= push && emit;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SIZE_X: size_x_q <= cfg_data;
					CFG_SIZE_Y: size_y_q <= cfg_data[SIZE_YZ_W-1:0];
					CFG_SIZE_Z: size_z_q <= cfg_data[SIZE_YZ_W-1:0];
					default: ;
				endcase
			end
			if (restart) begin
				pa_q     <= '0;
				pb_q     <= '0;
				pc_q     <= '0;
				pd_q     <= '0;
				fill_q   <= '0;
				oplane_q <= '0;
				orow_q   <= '0;
				ocol_q   <= '0;
			end else if (push) begin
				pa_q <= (PLANE_W'(pa_q) == len_a - PLANE_W'(1)) ? '0 : pa_q + LONG_AW'(1);
				pd_q <= (PLANE_W'(pd_q) == len_d - PLANE_W'(1)) ? '0 : pd_q + LONG_AW'(1);
				pb_q <= (pb_q == len_bc - SHORT_AW'(1)) ? '0 : pb_q + SHORT_AW'(1);
				pc_q <= (pc_q == len_bc - SHORT_AW'(1)) ? '0 : pc_q + SHORT_AW'(1);
				if (!emit) begin
					fill_q <= fill_q + PLANE_W'(1);
				end else if (col_end) begin
					ocol_q <= '0;
					if (row_end) begin
						orow_q   <= '0;
						oplane_q <= oplane_q + SIZE_X_W'(1);
					end else begin
						orow_q <= orow_q + ROW_W'(1);
					end
				end else begin
					ocol_q <= ocol_q + ROW_W'(1);
				end
			end
		end
	end

	always_comb begin
		enq_valid         = valid_s1_q;
		enq_data.center   = r1_q;
		enq_data.boundary = boundary_s1_q;
		enq_data.last     = last_s1_q;
		enq_data.sum      = SUM_W'(r0_q) + SUM_W'(a_rd) + SUM_W'(b_rd) + SUM_W'(r1_q)
			+ SUM_W'(r2_q) + SUM_W'(c_rd) + SUM_W'(d_rd);
	end

	a_last_is_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1_q && last_s1_q |-> boundary_s1_q)
		else $error("last voxel not flagged as boundary");
	a_counters_restart: assert property (@(posedge clk) disable iff (!arst_n)
		push && emit && is_last && !cfg_hit |=> fill_q == '0 && oplane_q == '0)
		else $error("counters did not restart after the final voxel");
endmodule

[design/s3a_queue.sv]
// Short queue of stencil records between front and back end.
module s3a_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       enq_valid,
	input  s3a_pkg::entry_t            enq_data,
	output logic                       deq_valid,
	input  logic                       deq_ready,
	output s3a_pkg::entry_t            deq_data,
	output logic [s3a_pkg::QCNT_W-1:0] count
);
	import s3a_pkg::*;

	entry_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q, rd_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               pop;

	assign deq_valid = cnt_q != '0;
	assign deq_data  = mem_q[rd_q];
	assign count     = cnt_q;
	assign pop       = deq_valid && deq_ready;

	always_ff @(posedge clk) begin
		if (enq_valid) begin
			mem_q[wr_q] <= enq_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq_valid) wr_q <= wr_q + QPTR_W'(1);
			if (pop)       rd_q <= rd_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(enq_valid) - QCNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		enq_valid |-> cnt_q < QCNT_W'(QDEPTH))
		else $error("stencil queue overflow");
	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		enq_valid && !pop |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
		else $error("stencil queue count lost a beat");
endmodule

[design/s3a_back.sv]
// Back end: divides the seven-voxel sum by seven, passes boundary centers through, holds the result beat.
module s3a_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            deq_valid,
	input  s3a_pkg::entry_t deq_data,
	output logic            deq_ready,
	s3a_out_if.source       out_ch
);
	import s3a_pkg::*;

	logic                     b1_valid_q, out_valid_q;
	logic [PROD_W-1:0]        prod_s1;
	logic signed [DATA_W-1:0] center_s1, voxel_q;
	logic                     boundary_s1, last_s1, last_q;
	logic [N_W-1:0]           n;
	logic                     adv_out, adv_b1;

	assign adv_out   = !out_valid_q || out_ch.ready;
	assign adv_b1    = !b1_valid_q || adv_out;
	assign deq_ready = adv_b1;
	assign n         = N_W'(deq_data.sum) + BIAS;

	always_ff @(posedge clk) begin
		if (adv_b1 && deq_valid) begin
			prod_s1     <= PROD_W'(n) * PROD_W'(RECIP);
			center_s1   <= deq_data.center;
			boundary_s1 <= deq_data.boundary;
			last_s1     <= deq_data.last;
		end
		if (adv_out && b1_valid_q) begin
			// low bits of the biased quotient equal the signed mean
			voxel_q <= boundary_s1 ? center_s1 : prod_s1[RECIP_SHIFT +: DATA_W];
			last_q  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_b1)  b1_valid_q  <= deq_valid;
			if (adv_out) out_valid_q <= b1_valid_q;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.voxel_out      = voxel_q;
	assign out_ch.last_of_volume = last_q;

	a_b1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		b1_valid_q && !adv_out |=> b1_valid_q && $stable(prod_s1))
		else $error("divide stage dropped a stalled beat");
endmodule

[design/stencil_3d_7point_average.sv]
// Top level of the streaming seven-point 3-D average, one sweep per pass.
//  channel  | dir | beat
//  in_ch    | in  | voxel_in (Q8.8), is_padding
//  out_ch   | out | voxel_out (Q8.8), last_of_volume
//  cfg      | in  | cfg_we, cfg_index, cfg_data (size_x, size_y, size_z)
// One voxel per cycle while in_ch.ready is high; a result leaves one plane of beats after its
// input, then passes the front register, queue, multiply stage and output register.
// Neighbors come from four delay RAMs (two plane-sized, two row-sized), one port each.
// Reset clears counters and sizes to 64; RAM contents stay undefined.
// A stalled output backs up the four-entry queue, then drops in_ch.ready.
module stencil_3d_7point_average (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [s3a_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [s3a_pkg::CFG_DATA_W-1:0]   cfg_data,
	s3a_in_if.sink                           in_ch,
	s3a_out_if.source                        out_ch
);
	import s3a_pkg::*;

	logic              enq_valid, deq_valid, deq_ready;
	entry_t            enq_data, deq_data;
	logic [QCNT_W-1:0] q_count;

	s3a_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .q_count(q_count),
		.enq_valid(enq_valid), .enq_data(enq_data));

	s3a_queue u_queue (
		.clk(clk), .arst_n(arst_n), .enq_valid(enq_valid), .enq_data(enq_data),
		.deq_valid(deq_valid), .deq_ready(deq_ready), .deq_data(deq_data),
		.count(q_count));

	s3a_back u_back (
		.clk(clk), .arst_n(arst_n), .deq_valid(deq_valid), .deq_data(deq_data),
		.deq_ready(deq_ready), .out_ch(out_ch));
endmodule

[tb/stencil_3d_7point_average_test.sv]
// Self-checking testbench for the streaming seven-point 3-D average block.
module stencil_3d_7point_average_test;
	import s3a_pkg::*;

	localparam int STORE_DEPTH = 2 * MAX_ROWS * MAX_COLS + 1;
	localparam int CYCLE_LIMIT = 900000;
	localparam int SETTLE = 24;

	typedef struct {
		logic [15:0] voxel;
		logic        pad;
	} beat_t;

	typedef struct {
		logic [15:0] voxel;
		logic        last;
	} result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	s3a_in_if  in_ch();
	s3a_out_if out_ch();

	stencil_3d_7point_average i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	beat_t   voxel_q[$];
	result_t stencil_q[$];
	int      errors;
	int      cycles;
	bit      quiet;
	bit      hold_start;
	int      hold_left;
	int      gap_left;
	int      stall_left;

	// predictor state
	logic [15:0] win_mem[STORE_DEPTH];
	int unsigned wr_ptr;
	longint unsigned in_pos;
	int unsigned o_plane, o_row, o_col;
	int unsigned raw_x, raw_y, raw_z;

	task automatic report(input string what);
		errors++;
		$display("mismatch at cycle %0d: %s", cycles, what);
	endtask

	function automatic int unsigned clampi(int unsigned v, int unsigned hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic longint tap(int unsigned window, int unsigned back);
		logic signed [15:0] v;
		v = win_mem[(wr_ptr + window - back) % window];
		return longint'(v);
	endfunction

	task automatic restart_stream();
		in_pos = 0;
		o_plane = 0;
		o_row = 0;
		o_col = 0;
		wr_ptr = 0;
	endtask

	task automatic predict_average(input beat_t b);
		int unsigned nx, ny, nz, plane, window;
		longint unsigned volume;
		longint s, res;
		bit emit, last;
		result_t r;
		nx = (raw_x < 3) ? 3 : raw_x;
		ny = clampi(raw_y, MAX_ROWS);
		nz = clampi(raw_z, MAX_COLS);
		plane = ny * nz;
		window = 2 * plane + 1;
		volume = longint'(nx) * plane;
		if (wr_ptr >= window)
			wr_ptr = 0;
		win_mem[wr_ptr] = b.pad ? 16'h0 : b.voxel;
		emit = in_pos >= plane;
		last = 0;
		if (emit) begin
			s = tap(window, plane);
			if (o_plane == 0 || o_plane == nx - 1 || o_row == 0 || o_row == ny - 1 ||
					o_col == 0 || o_col == nz - 1) begin
				res = s;
			end else begin
				s += tap(window, 2 * plane) + tap(window, 0) + tap(window, plane + nz)
					+ tap(window, plane - nz) + tap(window, plane + 1) + tap(window, plane - 1);
				res = (s + 3 + 7 * 65536) / 7 - 65536;
			end
			last = (o_plane == nx - 1 && o_row == ny - 1 && o_col == nz - 1);
			r.voxel = res[15:0];
			r.last = last;
			stencil_q.push_back(r);
		end
		wr_ptr = (wr_ptr + 1 == window) ? 0 : wr_ptr + 1;
		in_pos++;
		if (emit) begin
			if (last || in_pos >= volume + plane) begin
				restart_stream();
			end else begin
				o_col++;
				if (o_col >= nz) begin
					o_col = 0;
					o_row++;
					if (o_row >= ny) begin
						o_row = 0;
						o_plane++;
					end
				end
			end
		end
	endtask

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				predict_average(voxel_q[0]);
				voxel_q.pop_front();
			end else if (in_ch.valid) begin
				// beat still offered, keep it
			end
			if (in_ch.valid && !in_ch.ready) begin
				in_ch.valid <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_ch.valid <= 1'b0;
			end else if (voxel_q.size() == 0) begin
				in_ch.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				gap_left <= $urandom_range(0, 11);
				in_ch.valid <= 1'b0;
			end else begin
				in_ch.valid <= 1'b1;
				in_ch.voxel_in <= voxel_q[0].voxel;
				in_ch.is_padding <= voxel_q[0].pad;
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_start)
			hold_left <= 400;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (stencil_q.size() == 0) begin
					report("result beat with nothing expected");
				end else begin
					if (out_ch.voxel_out !== stencil_q[0].voxel)
						report($sformatf("voxel_out %h, want %h", out_ch.voxel_out,
							stencil_q[0].voxel));
					if (out_ch.last_of_volume !== stencil_q[0].last)
						report($sformatf("last_of_volume %b, want %b", out_ch.last_of_volume,
							stencil_q[0].last));
					stencil_q.pop_front();
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left <= $urandom_range(0, 11);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= (hold_left == 0);
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_SIZE_X)
			raw_x = val;
		else if (idx == CFG_SIZE_Y)
			raw_y = val[6:0];
		else
			raw_z = val[6:0];
		restart_stream();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_sizes(input int x, input int y, input int z);
		write_reg(CFG_SIZE_X, 16'(x));
		write_reg(CFG_SIZE_Y, {9'($urandom), 7'(y)});
		write_reg(CFG_SIZE_Z, {9'($urandom), 7'(z)});
	endtask

	task automatic drain();
		while (voxel_q.size() != 0 || stencil_q.size() != 0 || in_ch.valid)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_voxel();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_beat(input logic [15:0] v, input logic p);
		beat_t b;
		b.voxel = v;
		b.pad = p;
		voxel_q.push_back(b);
	endtask

	// one volume plus its flush plane; a few padding beats inside, some voxels in the flush
	task automatic push_volume(input int nx, input int ny, input int nz);
		for (int i = 0; i < nx * ny * nz; i++)
			push_beat(pick_voxel(), $urandom_range(0, 39) == 0);
		for (int i = 0; i < ny * nz; i++)
			push_beat(pick_voxel(), $urandom_range(0, 4) != 0);
	endtask

	function automatic int raw_yz();
		case ($urandom_range(0, 15))
			0: return $urandom_range(0, 2);
			1: return $urandom_range(7, 9);
			default: return $urandom_range(3, 6);
		endcase
	endfunction

	initial begin
		int sent, ex, ey, ez, rx, ry, rz;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_SIZE_X;
		cfg_data = 0;
		in_ch.valid = 0;
		in_ch.voxel_in = 0;
		in_ch.is_padding = 0;
		out_ch.ready = 0;
		errors = 0;
		cycles = 0;
		quiet = 0;
		hold_start = 0;
		hold_left = 0;
		gap_left = 0;
		stall_left = 0;
		raw_x = 64;
		raw_y = 64;
		raw_z = 64;
		foreach (win_mem[i])
			win_mem[i] = 16'h0;
		restart_stream();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: smallest grid, extremes, all-max and all-min planes
		set_sizes(3, 3, 3);
		for (int i = 0; i < 27; i++)
			push_beat((i < 9) ? 16'h7fff : (i < 18 ? 16'h8000 : 16'h7fff), i == 20);
		for (int i = 0; i < 9; i++)
			push_beat(16'h1234, i % 2);
		drain();

		// receiver holds off long so the queue fills and input stalls
		set_sizes(3, 6, 6);
		@(posedge clk);
		hold_start <= 1;
		@(posedge clk);
		hold_start <= 0;
		push_volume(3, 6, 6);
		drain();

		// largest plane count, cut short by a register write
		set_sizes(65535, 3, 3);
		for (int i = 0; i < 60; i++)
			push_beat(pick_voxel(), 0);
		drain();

		// saturated sizes, full-width rows; partial volume reaching interior voxels
		set_sizes(0, 0, 127);
		for (int i = 0; i < 460; i++)
			push_beat(pick_voxel(), $urandom_range(0, 19) == 0);
		drain();

		// row count above the limit saturates to the largest plane height
		set_sizes(4, 127, 3);
		for (int i = 0; i < 400; i++)
			push_beat(pick_voxel(), 0);
		drain();

		sent = 0;
		while (sent < 600) begin
			rx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
			ry = raw_yz();
			rz = raw_yz();
			ex = rx < 3 ? 3 : rx;
			ey = ry < 3 ? 3 : (ry > 64 ? 64 : ry);
			ez = rz < 3 ? 3 : (rz > 64 ? 64 : rz);
			if (sent > 450)
				quiet = 1;
			set_sizes(rx, ry, rz);
			repeat ($urandom_range(1, 3))
				push_volume(ex, ey, ez);
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, ex * ey * ez))
					push_beat(pick_voxel(), 0);
			sent += voxel_q.size();
			drain();
		end

		if (stencil_q.size() != 0)
			report($sformatf("%0d results never arrived", stencil_q.size()));
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

[sim.f]
design/s3a_pkg.sv
design/s3a_if.sv
design/s3a_ram.sv
design/s3a_front.sv
design/s3a_queue.sv
design/s3a_back.sv
design/stencil_3d_7point_average.sv
tb/stencil_3d_7point_average_test.sv
